@@ src/md4_pkg.sv @@
// Package with the shared types, constants and step functions of the MD4 digest block.
`default_nettype none

package md4_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5a827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam logic [5:0]  LAST_STEP = 6'd47;
  localparam logic [6:0]  FULL_BLOCK = 7'd64;

  typedef enum logic [1:0] {
    BLK_DATA   = 2'd0,
    BLK_PAD    = 2'd1,
    BLK_PADLEN = 2'd2,
    BLK_LEN    = 2'd3
  } blk_e;

  typedef struct packed {
    logic       absorb;
    logic       step;
    logic       add;
    logic       init;
    logic [5:0] step_idx;
    blk_e       kind;
    logic [1:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } sts_t;

  function automatic logic [3:0] word_sel(input logic [5:0] step);
    logic [3:0] i;
    logic [3:0] sel;
    i = step[3:0];
    case (step[5:4])
      2'd0:    sel = i;
      2'd1:    sel = {i[1:0], i[3:2]};
      default: sel = {i[0], i[1], i[2], i[3]};
    endcase
    return sel;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] step);
    logic [4:0] s;
    case ({step[5:4], step[1:0]})
      4'b0000: s = 5'd3;
      4'b0001: s = 5'd7;
      4'b0010: s = 5'd11;
      4'b0011: s = 5'd19;
      4'b0100: s = 5'd3;
      4'b0101: s = 5'd5;
      4'b0110: s = 5'd9;
      4'b0111: s = 5'd13;
      4'b1000: s = 5'd3;
      4'b1001: s = 5'd9;
      4'b1010: s = 5'd11;
      default: s = 5'd15;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

`default_nettype wire

@@ src/md4_if.sv @@
// Interfaces of the byte input channel and the digest output channel.
`default_nettype none

interface md4_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface md4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

@@ src/md4_message_digest.sv @@
// Top level of the MD4 message digest block.
// The block takes one message byte per transaction, one transaction per cycle while it
// gathers a 64-byte block. Each full block is compressed by one shared MD4 step unit, which
// runs every MD4 step (ST_COMP) and then adds into the chaining words (ST_ADD), so the input
// stalls during both after every 64th byte. A transaction with end_of_message set passes
// through ST_PADSEL to choose the padding, then one or two more compressions, after which
// the four digest words A, B, C, D leave as four output transactions, last_word marking D.
// The block then starts from the initial chaining value again and accepts the next message.
`default_nettype none

module md4_message_digest
  import md4_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  md4_in_if.sink    in_i,
  md4_out_if.source out_o
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] digest_word;

  md4_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .byte_valid_i     (in_i.byte_valid),
    .end_of_message_i (in_i.end_of_message),
    .in_ready_o       (in_i.ready),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .sts_i            (sts),
    .cmd_o            (cmd)
  );

  md4_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_i.data_byte),
    .sts_o         (sts),
    .digest_word_o (digest_word)
  );

  assign out_o.digest_word = digest_word;
  assign out_o.word_index  = cmd.out_idx;
  assign out_o.last_word   = (cmd.out_idx == 2'd3);

endmodule

`default_nettype wire

@@ src/md4_datapath.sv @@
// Datapath of the MD4 block: block buffer, length counter, chaining words and step logic.
`default_nettype none

module md4_datapath
  import md4_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire logic [7:0]  data_byte_i,
  output      sts_t        sts_o,
  output      logic [31:0] digest_word_o
);

  logic [31:0] buf_q [16];
  logic [5:0]  fill_q, fill_d;
  logic [60:0] cnt_q, cnt_d;
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] va_q, vb_q, vc_q, vd_q;
  logic [31:0] va_d, vb_d, vc_d, vd_d;

  logic [63:0] len_bits;
  logic [3:0]  wsel;
  logic [31:0] wraw;
  logic [31:0] wblk;
  logic [6:0]  limit;
  logic        mark_en;
  logic        len_en;
  logic [31:0] fval;
  logic [31:0] sum;
  logic [31:0] new_a;

  assign len_bits = {cnt_q, 3'b000};
  assign wsel = word_sel(cmd_i.step_idx);
  assign wraw = buf_q[wsel];

  always_comb begin
    limit   = FULL_BLOCK;
    mark_en = 1'b0;
    len_en  = 1'b0;
    case (cmd_i.kind)
      BLK_DATA: begin
        limit = FULL_BLOCK;
      end
      BLK_PAD: begin
        limit   = {1'b0, fill_q};
        mark_en = 1'b1;
      end
      BLK_PADLEN: begin
        limit   = {1'b0, fill_q};
        mark_en = 1'b1;
        len_en  = 1'b1;
      end
      default: begin
        limit  = 7'd0;
        len_en = 1'b1;
      end
    endcase
  end

  always_comb begin
    logic [6:0] pos;
    for (int b = 0; b < 4; b++) begin
      pos = {1'b0, wsel, 2'(b)};
      if (pos < limit) begin
        wblk[8*b +: 8] = wraw[8*b +: 8];
      end else if (mark_en && pos == limit) begin
        wblk[8*b +: 8] = PAD_MARK;
      end else if (len_en && wsel == 4'd14) begin
        wblk[8*b +: 8] = len_bits[8*b +: 8];
      end else if (len_en && wsel == 4'd15) begin
        wblk[8*b +: 8] = len_bits[32 + 8*b +: 8];
      end else begin
        wblk[8*b +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    case (cmd_i.step_idx[5:4])
      2'd0:    fval = (vb_q & vc_q) | (~vb_q & vd_q);
      2'd1:    fval = ((vb_q & vc_q) | (vb_q & vd_q) | (vc_q & vd_q)) + K_ROUND2;
      default: fval = (vb_q ^ vc_q ^ vd_q) + K_ROUND3;
    endcase
  end

  assign sum   = va_q + fval + wblk;
  assign new_a = rotl32(sum, rot_amt(cmd_i.step_idx));

  always_comb begin
    fill_d = fill_q;
    cnt_d  = cnt_q;
    va_d   = va_q;
    vb_d   = vb_q;
    vc_d   = vc_q;
    vd_d   = vd_q;
    for (int k = 0; k < 4; k++) begin
      chain_d[k] = chain_q[k];
    end
    if (cmd_i.init) begin
      fill_d     = 6'd0;
      cnt_d      = '0;
      chain_d[0] = IV_A;
      chain_d[1] = IV_B;
      chain_d[2] = IV_C;
      chain_d[3] = IV_D;
      va_d       = IV_A;
      vb_d       = IV_B;
      vc_d       = IV_C;
      vd_d       = IV_D;
    end else if (cmd_i.absorb) begin
      fill_d = fill_q + 6'd1;
      cnt_d  = cnt_q + 61'd1;
    end else if (cmd_i.step) begin
      va_d = vd_q;
      vb_d = new_a;
      vc_d = vb_q;
      vd_d = vc_q;
    end else if (cmd_i.add) begin
      chain_d[0] = chain_q[0] + va_q;
      chain_d[1] = chain_q[1] + vb_q;
      chain_d[2] = chain_q[2] + vc_q;
      chain_d[3] = chain_q[3] + vd_q;
      va_d       = chain_d[0];
      vb_d       = chain_d[1];
      vc_d       = chain_d[2];
      vd_d       = chain_d[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= 6'd0;
      cnt_q      <= '0;
      chain_q[0] <= IV_A;
      chain_q[1] <= IV_B;
      chain_q[2] <= IV_C;
      chain_q[3] <= IV_D;
      va_q       <= IV_A;
      vb_q       <= IV_B;
      vc_q       <= IV_C;
      vd_q       <= IV_D;
    end else begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      for (int k = 0; k < 4; k++) begin
        chain_q[k] <= chain_d[k];
      end
      va_q <= va_d;
      vb_q <= vb_d;
      vc_q <= vc_d;
      vd_q <= vd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb) begin
      buf_q[fill_q[5:2]][8*fill_q[1:0] +: 8] <= data_byte_i;
    end
  end

  assign sts_o.fill    = fill_q;
  assign digest_word_o = chain_q[cmd_i.out_idx];

endmodule

`default_nettype wire

@@ src/md4_ctrl.sv @@
// Controller of the MD4 block: byte intake, block sequencing, padding and digest output.
`default_nettype none

module md4_ctrl
  import md4_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic byte_valid_i,
  input  wire logic end_of_message_i,
  output      logic in_ready_o,
  output      logic out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output      cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PADSEL = 5'b00010,
    ST_COMP   = 5'b00100,
    ST_ADD    = 5'b01000,
    ST_OUT    = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] step_q, step_d;
  logic [1:0] idx_q, idx_d;
  blk_e       kind_q, kind_d;
  logic       end_q, end_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    idx_d   = idx_q;
    kind_d  = kind_q;
    end_d   = end_q;
    cmd_o   = '{absorb: 1'b0, step: 1'b0, add: 1'b0, init: 1'b0,
                step_idx: step_q, kind: kind_q, out_idx: idx_q};
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_valid_i) begin
            cmd_o.absorb = 1'b1;
            if (sts_i.fill == 6'd63) begin
              kind_d  = BLK_DATA;
              end_d   = end_of_message_i;
              step_d  = 6'd0;
              state_d = ST_COMP;
            end else if (end_of_message_i) begin
              state_d = ST_PADSEL;
            end
          end else if (end_of_message_i) begin
            state_d = ST_PADSEL;
          end
        end
      end
      ST_PADSEL: begin
        kind_d  = (sts_i.fill[5:3] == 3'b111) ? BLK_PAD : BLK_PADLEN;
        step_d  = 6'd0;
        state_d = ST_COMP;
      end
      ST_COMP: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 6'd1;
        if (step_q == LAST_STEP) begin
          step_d  = 6'd0;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        case (kind_q)
          BLK_DATA: begin
            state_d = end_q ? ST_PADSEL : ST_IDLE;
          end
          BLK_PAD: begin
            kind_d  = BLK_LEN;
            state_d = ST_COMP;
          end
          default: begin
            idx_d   = 2'd0;
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            cmd_o.init = 1'b1;
            end_d      = 1'b0;
            state_d    = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 6'd0;
      idx_q   <= 2'd0;
      kind_q  <= BLK_DATA;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      kind_q  <= kind_d;
      end_q   <= end_d;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for md4_message_digest with a built-in MD4 digest predictor.
`timescale 1ns / 100ps

module tb_top;
  import md4_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 120;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 480;
  localparam int MIN_MESSAGES = 12;
  localparam int MSG_WORD [48] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
    0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15,
    0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15
  };
  localparam int ROT_BITS [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        is_last;
  } digest_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  md4_in_if  in_bus ();
  md4_out_if out_bus ();

  md4_message_digest DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  logic [31:0]  chain_q [4];
  logic [7:0]   block_q [64];
  int unsigned  fill_q;
  logic [63:0]  nbits_q;
  digest_word_t pending_digest_words [$];

  int error_count = 0;
  int cycle_count = 0;
  int item_count = 0;
  int message_count = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void restart_digest();
    chain_q = '{IV_A, IV_B, IV_C, IV_D};
    fill_q = 0;
    nbits_q = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] x [16];
    logic [31:0] a, b, c, d, f, k, t;
    int r, sh;
    for (int i = 0; i < 16; i++) begin
      x[i] = {block_q[4*i+3], block_q[4*i+2], block_q[4*i+1], block_q[4*i]};
    end
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (int s = 0; s < 48; s++) begin
      r = s / 16;
      case (r)
        0: begin
          f = (b & c) | (~b & d);
          k = '0;
        end
        1: begin
          f = (b & c) | (b & d) | (c & d);
          k = K_ROUND2;
        end
        default: begin
          f = b ^ c ^ d;
          k = K_ROUND3;
        end
      endcase
      sh = ROT_BITS[r * 4 + s % 4];
      t = a + f + k + x[MSG_WORD[s]];
      t = (t << sh) | (t >> (32 - sh));
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
  endfunction

  function automatic void absorb_item(logic [7:0] data, logic bv, logic eom);
    if (bv) begin
      block_q[fill_q] = data;
      fill_q++;
      nbits_q += 64'd8;
      if (fill_q == 64) begin
        compress_block();
        fill_q = 0;
      end
    end
    if (eom) begin
      block_q[fill_q] = PAD_MARK;
      fill_q++;
      for (int i = fill_q; i < 64; i++) block_q[i] = 8'h00;
      if (fill_q > 56) begin
        compress_block();
        for (int i = 0; i < 64; i++) block_q[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) block_q[56 + i] = nbits_q[8*i +: 8];
      compress_block();
      for (int i = 0; i < 4; i++) begin
        pending_digest_words.push_back(
          digest_word_t'{word: chain_q[i], idx: i[1:0], is_last: (i == 3)});
      end
      restart_digest();
    end
  endfunction

  task automatic note_mismatch(input string what, input digest_word_t want,
                               input digest_word_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s: expected word %h index %0d last %0b, got word %h index %0d last %0b",
               what, want.word, want.idx, want.is_last, got.word, got.idx, got.is_last);
    end
  endtask

  always @(posedge clk_i) begin
    digest_word_t got;
    digest_word_t want;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        absorb_item(in_bus.data_byte, in_bus.byte_valid, in_bus.end_of_message);
      end
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.digest_word, out_bus.word_index, out_bus.last_word};
        if (pending_digest_words.size() == 0) begin
          note_mismatch("Unexpected digest transaction", '0, got);
        end else begin
          want = pending_digest_words.pop_front();
          if (got.word !== want.word || got.idx !== want.idx || got.is_last !== want.is_last) begin
            note_mismatch("Digest mismatch", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  task automatic send_item(input logic [7:0] data, input logic bv, input logic eom);
    int gap;
    if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= data;
    in_bus.byte_valid <= bv;
    in_bus.end_of_message <= eom;
    do @(posedge clk_i); while (!in_bus.ready);
    if (bv || eom) item_count++;
    if (eom) message_count++;
  endtask

  task automatic send_idle();
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  task automatic wait_digests_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_digest_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_idle_and_empty();
    send_idle();
    send_idle();
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    wait_digests_drained();
  endtask

  task automatic test_byte_with_end();
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    wait_digests_drained();
  endtask

  task automatic test_short_messages();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_idle();
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    wait_digests_drained();
  endtask

  task automatic test_random_messages();
    int picks [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int first_item;
    int first_message;
    int len;
    int kind;
    bit end_on_byte;
    first_item = item_count;
    first_message = message_count;
    while (item_count - first_item < RANDOM_ITEMS ||
           message_count - first_message < MIN_MESSAGES) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) len = $urandom_range(0, 8);
      else if (kind < 7) len = picks[$urandom_range(0, 9)];
      else len = $urandom_range(0, 130);
      end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(0, 7) == 0) send_idle();
        send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (n == len - 1));
      end
      if (!end_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      if (message_count - first_message == 6) wait_digests_drained();
    end
  endtask

  initial begin
    in_bus.valid <= 1'b0;
    in_bus.data_byte <= 8'h00;
    in_bus.byte_valid <= 1'b0;
    in_bus.end_of_message <= 1'b0;
    rst_ni <= 1'b0;
    restart_digest();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_and_empty();
    test_byte_with_end();
    test_short_messages();
    test_random_messages();

    wait_digests_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_digest_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ md4_message_digest.f @@
src/md4_pkg.sv
src/md4_if.sv
src/md4_datapath.sv
src/md4_ctrl.sv
src/md4_message_digest.sv
tb/tb_top.sv
